### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/grc_pkg.sv
package grc_pkg;

  // Fixed row format of the matrix ports.
  localparam int ROW_W     = 32;
  localparam int ROW_IDX_W = 5;
  localparam int CFG_W     = 6;

  localparam int NODE_COUNT_RESET  = 32;
  localparam int MAX_NODES_DEFAULT = 32;

  // What every cell of the chain does in one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_CLOSE
  } cell_op_t;

  // Control word from the sequencer to the cells and the output stage.
  typedef struct packed {
    cell_op_t               op;
    logic [ROW_IDX_W-1:0]   pivot_col;
    logic                   emit;
    logic [ROW_IDX_W-1:0]   emit_index;
    logic                   emit_last;
  } grc_ctl_t;

endpackage

### rtl/core/grc_cell.sv
module grc_cell (
  input  logic                         clk,
  input  grc_pkg::grc_ctl_t            ctl,
  input  logic [grc_pkg::ROW_W-1:0]    shift_in,
  input  logic [grc_pkg::ROW_W-1:0]    pivot_row,
  output logic [grc_pkg::ROW_W-1:0]    row
);
  import grc_pkg::*;

  // On close, a row that reaches the pivot takes on all the pivot reaches.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_SHIFT: begin
        row <= shift_in;
      end
      CELL_CLOSE: begin
        if (row[ctl.pivot_col]) begin
          row <= row | pivot_row;
        end
      end
      default: begin
        row <= row;
      end
    endcase
  end

endmodule

### rtl/core/grc_ctrl.sv
module grc_ctrl #(
  parameter  int NODE_LIMIT = 32,
  localparam int CNT_W      = $clog2(NODE_LIMIT + 1),
  localparam int IDX_W      = $clog2(NODE_LIMIT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        node_count_we,
  input  logic [grc_pkg::CFG_W-1:0]   node_count_wdata,
  output logic                        busy,
  output grc_pkg::grc_ctl_t           ctl,
  output logic [CNT_W-1:0]            active_n,
  output logic [IDX_W-1:0]            tail_sel,
  output logic [IDX_W-1:0]            pivot_sel
);
  import grc_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CLOSE,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CFG_W-1:0]  node_count;
  logic [CNT_W-1:0]  last_count;
  logic              at_last;
  logic              accept;

  // A zero count means one node; a count above the row limit saturates.
  always_comb begin
    if (node_count == '0) begin
      active_n = CNT_W'(1);
    end else if (node_count > CFG_W'(NODE_LIMIT)) begin
      active_n = CNT_W'(NODE_LIMIT);
    end else begin
      active_n = CNT_W'(node_count);
    end
  end

  assign last_count = CNT_W'(active_n - CNT_W'(1));
  assign at_last    = (count == last_count);
  assign accept     = start && (state == ST_LOAD);
  assign busy       = (state != ST_LOAD);
  assign tail_sel   = IDX_W'(last_count);
  assign pivot_sel  = IDX_W'(last_count - count);

  always_comb begin
    unique case (state)
      ST_LOAD:  ctl.op = accept ? CELL_SHIFT : CELL_HOLD;
      ST_CLOSE: ctl.op = CELL_CLOSE;
      ST_EMIT:  ctl.op = CELL_SHIFT;
      default:  ctl.op = CELL_HOLD;
    endcase
    ctl.pivot_col  = ROW_IDX_W'(count);
    ctl.emit       = (state == ST_EMIT);
    ctl.emit_index = ROW_IDX_W'(count);
    ctl.emit_last  = at_last;
  end

  // One counter serves as row count, pivot and emit index in turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      node_count <= CFG_W'(NODE_COUNT_RESET);
    end else if (node_count_we) begin
      node_count <= node_count_wdata;
      state      <= ST_LOAD;
      count      <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (at_last) begin
              state <= ST_CLOSE;
              count <= '0;
            end else begin
              count <= CNT_W'(count + CNT_W'(1));
            end
          end
        end
        ST_CLOSE: begin
          if (at_last) begin
            state <= ST_EMIT;
            count <= '0;
          end else begin
            count <= CNT_W'(count + CNT_W'(1));
          end
        end
        ST_EMIT: begin
          if (at_last) begin
            state <= ST_LOAD;
            count <= '0;
          end else begin
            count <= CNT_W'(count + CNT_W'(1));
          end
        end
        default: begin
          state <= ST_LOAD;
          count <= '0;
        end
      endcase
    end
  end

endmodule

### rtl/core/graph_reachability_closure_core.sv
// Channel      | Handshake                     | Payload
// -------------+-------------------------------+-----------------------------------
// row in       | start, !busy (accept: both)   | row_bits[31:0]
// reach out    | done (high with each row)     | row_index[4:0], reach_bits, last_row
// node count   | node_count_we                 | node_count_wdata[5:0]
//
// A frame of n nodes is loaded one word per cycle while start is high, busy low,
// then closed one pivot at a time, then emitted; no word is taken until emit ends.
// The closure length is set by the one pivot row that is broadcast per cycle.
// The first result word comes out of the output register after the closure steps.
// Reset is synchronous and active high; it returns to loading with a node count of 32.
// The receiver cannot stall: every result word is shown for exactly one cycle.
module graph_reachability_closure_core #(
  parameter int MAX_NODES = grc_pkg::MAX_NODES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [grc_pkg::ROW_W-1:0]       row_bits,
  input  logic                            node_count_we,
  input  logic [grc_pkg::CFG_W-1:0]       node_count_wdata,
  output logic                            done,
  output logic [grc_pkg::ROW_IDX_W-1:0]   row_index,
  output logic [grc_pkg::ROW_W-1:0]       reach_bits,
  output logic                            last_row
);
  import grc_pkg::*;

  // The number of rows held is bounded both by the parameter and by the row width.
  localparam int NODE_LIMIT = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int CNT_W      = $clog2(NODE_LIMIT + 1);
  localparam int IDX_W      = $clog2(NODE_LIMIT);

  grc_ctl_t          ctl;
  logic [CNT_W-1:0]  active_n;
  logic [IDX_W-1:0]  tail_sel;
  logic [IDX_W-1:0]  pivot_sel;
  logic [ROW_W-1:0]  row_mask;
  logic [ROW_W-1:0]  load_row;
  logic [ROW_W-1:0]  pivot_row;
  logic [ROW_W-1:0]  cell_row [NODE_LIMIT];

  grc_ctrl #(
    .NODE_LIMIT (NODE_LIMIT)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .node_count_we    (node_count_we),
    .node_count_wdata (node_count_wdata),
    .busy             (busy),
    .ctl              (ctl),
    .active_n         (active_n),
    .tail_sel         (tail_sel),
    .pivot_sel        (pivot_sel)
  );

  // Bits at or above the node count are dropped as a word is loaded. The closure
  // only ORs masked rows together, so they stay clear to the end.
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      row_mask[j] = (CFG_W'(j) < CFG_W'(active_n));
    end
  end

  assign load_row = row_bits & row_mask;

  // The chain shifts toward the higher cells. After n loads, row i sits in cell
  // n-1-i, so row 0 is at the tail (cell n-1) and leaves first when emitting.
  // Pivot k is therefore read from cell n-1-k and broadcast to every cell.
  assign pivot_row = cell_row[pivot_sel];

  for (genvar i = 0; i < NODE_LIMIT; i++) begin : g_cell
    logic [ROW_W-1:0] shift_in;

    if (i == 0) begin : g_head
      assign shift_in = load_row;
    end else begin : g_link
      assign shift_in = cell_row[i-1];
    end

    grc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .shift_in  (shift_in),
      .pivot_row (pivot_row),
      .row       (cell_row[i])
    );
  end

  // While emitting, the tail cell is captured each cycle as the chain moves on.
  // Cells fed from the head during this time never reach the tail within the
  // frame, so only loaded rows are ever sent out.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      row_index  <= ctl.emit_index;
      reach_bits <= cell_row[tail_sel];
      last_row   <= ctl.emit_last;
    end
  end

endmodule

### rtl/core/grc_checker.sv
`include "assert_macros.svh"

module grc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            busy,
  input  logic                            done,
  input  logic [grc_pkg::ROW_IDX_W-1:0]   row_index,
  input  logic                            last_row
);
  import grc_pkg::*;

  // Reset leaves the block idle with no result pending.
  `ASSERT_CLK(a_reset_idle, clk, rst |=> (!done && !busy), "block not idle after reset")

  // While a result row other than the final one is out, no new word can be taken.
  `ASSERT_CLK_RST(a_busy_mid_frame, clk, rst, (done && !last_row) |-> busy, "busy low mid-frame")

  // Result rows of a frame come on consecutive cycles in ascending order.
  `ASSERT_CLK_RST(a_rows_in_order, clk, rst, (done && !last_row) |=> (done && (row_index == ROW_IDX_W'($past(row_index) + 1'b1))), "result rows out of order")

  // The final row closes the burst.
  `ASSERT_CLK_RST(a_burst_ends, clk, rst, (done && last_row) |=> !done, "result after final row")

endmodule

bind graph_reachability_closure_core grc_checker u_grc_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .done      (done),
  .row_index (row_index),
  .last_row  (last_row)
);
